/* sv/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define SPR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define SPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/sprpwm_pkg.sv */
// Package: shared types and constants of the speed ramp PWM unit.
package sprpwm_pkg;

   // command codes
   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_SET   = 3'd1;
   localparam logic [2:0] OP_RAMP  = 3'd2;
   localparam logic [2:0] OP_START = 3'd3;
   localparam logic [2:0] OP_STOP  = 3'd4;

   // register map, index = paddr[3:2]
   localparam int         CSR_ADDR_W       = 4;
   localparam int         CSR_DATA_W       = 32;
   localparam logic [1:0] REG_TIMER_RELOAD = 2'd0;
   localparam logic [1:0] REG_RAMP_STEP    = 2'd1;
   localparam logic [1:0] REG_RAMP_PERIOD  = 2'd2;

   localparam int RELOAD_W = 16;
   localparam int STEP_W   = 7;
   localparam int RPER_W   = 16;
   localparam int PERIOD_W = 17;
   localparam int DUTY_W   = 17;
   localparam int SPEED_W  = 7;

   localparam logic [RELOAD_W-1:0] RELOAD_RST = 16'd1699;
   localparam logic [STEP_W-1:0]   STEP_RST   = 7'd1;
   localparam logic [RPER_W-1:0]   RPER_RST   = 16'd100;

   localparam int START_SPEED = 50;

   typedef struct packed {
      logic [STEP_W-1:0] step;
      logic [RPER_W-1:0] period;
   } ramp_cfg_type;

   typedef struct packed {
      logic pwm_on;
      logic ramp_busy;
   } ramp_flags_type;

endpackage

/* sv/sprpwm_cdiv.sv */
// Divide by a constant through an exact reciprocal multiply.
module sprpwm_cdiv #(
   parameter int DIVISOR = 100,
   parameter int IN_W    = 24,
   parameter int OUT_W   = 17
) (
   input  logic [IN_W-1:0]  dividend,
   output logic [OUT_W-1:0] quotient
);

   // rounded-up reciprocal; exact for every dividend below 2**IN_W
   localparam int          SHIFT    = IN_W + $clog2(DIVISOR);
   localparam int          RCP_W    = IN_W + 2;
   localparam int          PROD_W   = IN_W + RCP_W;
   localparam logic [63:0] RECIP_64 =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [RCP_W-1:0] RECIP = RCP_W'(RECIP_64);

   logic [PROD_W-1:0] prod;

   assign prod     = PROD_W'(dividend) * PROD_W'(RECIP);
   assign quotient = prod[SHIFT +: OUT_W];

endmodule

/* sv/sprpwm_ramp.sv */
// Speed command state: set, start/stop and timed ramp toward a target.
module sprpwm_ramp #(
   parameter int MAX_SPEED = 100,
   parameter int SPD_W     = 7
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic [2:0]                 op,
   input  logic [7:0]                 value,
   input  sprpwm_pkg::ramp_cfg_type   cfg,
   output logic [SPD_W-1:0]           speed_next,
   output sprpwm_pkg::ramp_flags_type flags_next
);

   localparam int CMP_W   = (SPD_W > sprpwm_pkg::STEP_W) ? SPD_W : sprpwm_pkg::STEP_W;
   localparam int VAL_W   = (SPD_W > 8) ? SPD_W : 8;
   localparam int START_I = (MAX_SPEED < sprpwm_pkg::START_SPEED) ?
                            MAX_SPEED : sprpwm_pkg::START_SPEED;
   localparam logic [SPD_W-1:0] MAX_V   = SPD_W'(MAX_SPEED);
   localparam logic [SPD_W-1:0] START_V = SPD_W'(START_I);

   logic [SPD_W-1:0]              speed_ff, speed_in;
   logic [SPD_W-1:0]              target_ff, target_in;
   logic                          ramp_on_ff, ramp_on_in;
   logic                          running_ff, running_in;
   logic [31:0]                   ms_ff, ms_in;
   logic [31:0]                   next_ff, next_in;
   logic [sprpwm_pkg::STEP_W-1:0] step_ff, step_in;
   logic [sprpwm_pkg::RPER_W-1:0] period_ff, period_in;

   logic [SPD_W-1:0] val_sat;
   logic [31:0]      ms_inc;
   logic [31:0]      gap;
   logic             due;
   logic             up;
   logic [SPD_W-1:0] diff;
   logic             near;
   logic [SPD_W-1:0] step_s;
   logic [SPD_W-1:0] stepped;

   assign val_sat = (VAL_W'(value) > VAL_W'(MAX_SPEED)) ? MAX_V : SPD_W'(VAL_W'(value));
   assign ms_inc  = ms_ff + 32'd1;
   assign gap     = ms_inc - next_ff;
   // step due when the signed distance to the step time is not negative
   assign due     = ramp_on_ff && !gap[31];
   assign up      = target_ff > speed_ff;
   assign diff    = up ? (target_ff - speed_ff) : (speed_ff - target_ff);
   assign near    = CMP_W'(diff) <= CMP_W'(step_ff);
   // truncation only matters when near is set, where step_s is unused
   assign step_s  = SPD_W'(step_ff);
   assign stepped = near ? target_ff : (up ? speed_ff + step_s : speed_ff - step_s);

   always_comb begin
      speed_in   = speed_ff;
      target_in  = target_ff;
      ramp_on_in = ramp_on_ff;
      running_in = running_ff;
      ms_in      = ms_ff;
      next_in    = next_ff;
      step_in    = step_ff;
      period_in  = period_ff;
      case (op)
         sprpwm_pkg::OP_TICK: begin
            ms_in = ms_inc;
            if (due) begin
               next_in = ms_inc + 32'(period_ff);
               if (speed_ff == target_ff) begin
                  ramp_on_in = 1'b0;
               end else begin
                  speed_in   = stepped;
                  ramp_on_in = (stepped != target_ff);
               end
            end
         end
         sprpwm_pkg::OP_SET: begin
            speed_in = val_sat;
         end
         sprpwm_pkg::OP_RAMP: begin
            target_in  = val_sat;
            step_in    = (cfg.step == '0) ? sprpwm_pkg::STEP_W'(1) : cfg.step;
            period_in  = cfg.period;
            ramp_on_in = 1'b1;
            next_in    = ms_ff + 32'(cfg.period);
         end
         sprpwm_pkg::OP_START: begin
            if (!running_ff) begin
               speed_in   = START_V;
               running_in = 1'b1;
            end
         end
         sprpwm_pkg::OP_STOP: begin
            running_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff   <= START_V;
         target_ff  <= START_V;
         ramp_on_ff <= 1'b0;
         running_ff <= 1'b0;
         ms_ff      <= '0;
         next_ff    <= '0;
         step_ff    <= sprpwm_pkg::STEP_RST;
         period_ff  <= sprpwm_pkg::RPER_RST;
      end else if (advance) begin
         speed_ff   <= speed_in;
         target_ff  <= target_in;
         ramp_on_ff <= ramp_on_in;
         running_ff <= running_in;
         ms_ff      <= ms_in;
         next_ff    <= next_in;
         step_ff    <= step_in;
         period_ff  <= period_in;
      end
   end

   assign speed_next           = speed_in;
   assign flags_next.pwm_on    = running_in;
   assign flags_next.ramp_busy = ramp_on_in;

endmodule

/* sv/speed_ramp_complementary_pwm_unit.sv */
// Top level: speed ramp unit with complementary PWM compare outputs.
// Takes one request per cycle while no stage is held by the result channel.
// Three stages: command register, state update plus period multiply, reciprocal divide
//   into the result register; a stage stalls only while its successor is full and held.
// Reset (synchronous, active high): pipeline empty, registers at defaults, speed and
//   target at 50 (capped at MAX_SPEED), ramp idle, PWM off, time zero.
`include "assert_macros.svh"

module speed_ramp_complementary_pwm_unit #(
   parameter int MAX_SPEED = 100
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [2:0]                        req_operation,
   input  logic [7:0]                        req_value,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [sprpwm_pkg::SPEED_W-1:0]    rsp_speed_now,
   output logic [sprpwm_pkg::DUTY_W-1:0]     rsp_duty_main,
   output logic [sprpwm_pkg::DUTY_W-1:0]     rsp_duty_comp,
   output logic                              rsp_pwm_on,
   output logic                              rsp_ramp_busy,
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sprpwm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sprpwm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sprpwm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                              csr_pready
);

   localparam int SPD_W  = $clog2(MAX_SPEED + 1);
   localparam int SPDX_W = (SPD_W > sprpwm_pkg::SPEED_W) ? SPD_W : sprpwm_pkg::SPEED_W;
   // product of a speed and a timer period
   localparam int P_W    = SPD_W + sprpwm_pkg::PERIOD_W;
   localparam logic [SPD_W-1:0] MAX_V = SPD_W'(MAX_SPEED);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [sprpwm_pkg::RELOAD_W-1:0] timer_reload_ff;
   logic [sprpwm_pkg::STEP_W-1:0]   ramp_step_ff;
   logic [sprpwm_pkg::RPER_W-1:0]   ramp_period_ff;
   logic                            csr_wr;
   logic [1:0]                      csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_reload_ff <= sprpwm_pkg::RELOAD_RST;
         ramp_step_ff    <= sprpwm_pkg::STEP_RST;
         ramp_period_ff  <= sprpwm_pkg::RPER_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            sprpwm_pkg::REG_TIMER_RELOAD: timer_reload_ff <= csr_pwdata[15:0];
            sprpwm_pkg::REG_RAMP_STEP:    ramp_step_ff    <= csr_pwdata[6:0];
            sprpwm_pkg::REG_RAMP_PERIOD:  ramp_period_ff  <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         sprpwm_pkg::REG_TIMER_RELOAD: csr_prdata = 32'(timer_reload_ff);
         sprpwm_pkg::REG_RAMP_STEP:    csr_prdata = 32'(ramp_step_ff);
         sprpwm_pkg::REG_RAMP_PERIOD:  csr_prdata = 32'(ramp_period_ff);
         default:                      csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Pipeline flow control: a stage takes a new transfer when it is
   // empty or when its content moves on in the same cycle.
   // ---------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;
   logic adv1;

   assign rdy3      = !v3_ff || rsp_ready;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign adv1      = v1_ff && rdy2;
   assign req_ready = rdy1;
   assign rsp_valid = v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: command register
   // ---------------------------------------------------------------
   logic [2:0] s1_op_ff;
   logic [7:0] s1_value_ff;

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_op_ff    <= req_operation;
         s1_value_ff <= req_value;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: state update and period products
   // ---------------------------------------------------------------
   sprpwm_pkg::ramp_cfg_type   ramp_cfg;
   sprpwm_pkg::ramp_flags_type flags_next;
   logic [SPD_W-1:0]           speed_next;

   assign ramp_cfg.step   = ramp_step_ff;
   assign ramp_cfg.period = ramp_period_ff;

   // speed state changes only when the command leaves stage 1
   sprpwm_ramp #(
      .MAX_SPEED (MAX_SPEED),
      .SPD_W     (SPD_W)
   ) u_ramp (
      .clock      (clock),
      .reset      (reset),
      .advance    (adv1),
      .op         (s1_op_ff),
      .value      (s1_value_ff),
      .cfg        (ramp_cfg),
      .speed_next (speed_next),
      .flags_next (flags_next)
   );

   logic [sprpwm_pkg::PERIOD_W-1:0] period;
   logic [P_W-1:0]                  prod_main, prod_comp;

   logic [SPD_W-1:0]                s2_speed_ff;
   sprpwm_pkg::ramp_flags_type      s2_flags_ff;
   logic [P_W-1:0]                  s2_main_ff, s2_comp_ff;
   logic [sprpwm_pkg::PERIOD_W-1:0] s2_period_ff;

   assign period    = sprpwm_pkg::PERIOD_W'(timer_reload_ff) + sprpwm_pkg::PERIOD_W'(1);
   assign prod_main = P_W'(speed_next) * P_W'(period);
   assign prod_comp = P_W'(MAX_V - speed_next) * P_W'(period);

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_speed_ff  <= speed_next;
         s2_flags_ff  <= flags_next;
         s2_main_ff   <= prod_main;
         s2_comp_ff   <= prod_comp;
         s2_period_ff <= period;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: divide by MAX_SPEED, result register
   // ---------------------------------------------------------------
   logic [sprpwm_pkg::DUTY_W-1:0] q_main, q_comp;
   logic [SPDX_W-1:0]             s2_speed_x;

   sprpwm_cdiv #(
      .DIVISOR (MAX_SPEED),
      .IN_W    (P_W),
      .OUT_W   (sprpwm_pkg::DUTY_W)
   ) u_div_main (
      .dividend (s2_main_ff),
      .quotient (q_main)
   );

   sprpwm_cdiv #(
      .DIVISOR (MAX_SPEED),
      .IN_W    (P_W),
      .OUT_W   (sprpwm_pkg::DUTY_W)
   ) u_div_comp (
      .dividend (s2_comp_ff),
      .quotient (q_comp)
   );

   // speed output carries the low seven bits of the speed command
   assign s2_speed_x = SPDX_W'(s2_speed_ff);

   always_ff @(posedge clock) begin
      if (rdy3) begin
         rsp_speed_now <= s2_speed_x[sprpwm_pkg::SPEED_W-1:0];
         rsp_duty_main <= q_main;
         rsp_duty_comp <= q_comp;
         rsp_pwm_on    <= s2_flags_ff.pwm_on;
         rsp_ramp_busy <= s2_flags_ff.ramp_busy;
      end
   end

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   logic [sprpwm_pkg::DUTY_W:0] duty_sum;
   logic [sprpwm_pkg::DUTY_W:0] period_x;
   logic                        split_ok;
   logic                        s1_stall;
   logic [10:0]                 s1_cmd;
   logic                        pipe_busy;

   assign duty_sum  = {1'b0, q_main} + {1'b0, q_comp};
   assign period_x  = {1'b0, s2_period_ff};
   // truncated shares add up to the period or one less
   assign split_ok  = (duty_sum <= period_x) && (duty_sum + 1'b1 >= period_x);
   assign s1_stall  = v1_ff && !rdy2;
   assign s1_cmd    = {s1_op_ff, s1_value_ff};
   assign pipe_busy = v1_ff || v2_ff || v3_ff;

   `SPR_ASSERT(a_speed_cap, clock, reset, v2_ff |-> (s2_speed_ff <= MAX_V), "speed above max")
   `SPR_ASSERT(a_duty_split, clock, reset, v2_ff |-> split_ok, "compare values split wrong")
   `SPR_ASSERT(a_s1_hold, clock, reset, s1_stall |=> (v1_ff && $stable(s1_cmd)), "command lost")
   `SPR_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) && !reset |-> !pipe_busy, "busy after reset")

endmodule
